### rtl/tkmp_pkg.sv
package tkmp_pkg;

  // Parser states: idle, after ESC, after ESC-[, and the three mouse report bytes.
  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_ESC  = 3'd1,
    ST_CSI  = 3'd2,
    ST_MBTN = 3'd3,
    ST_MCOL = 3'd4,
    ST_MROW = 3'd5
  } parse_state_t;

  // Event kinds reported on the result channel.
  typedef enum logic [1:0] {
    EV_KEY   = 2'd0,
    EV_ARROW = 2'd1,
    EV_MOUSE = 2'd2
  } ev_type_t;

  // Arrow key codes.
  localparam logic [2:0] KC_NONE  = 3'd0;
  localparam logic [2:0] KC_UP    = 3'd1;
  localparam logic [2:0] KC_DOWN  = 3'd2;
  localparam logic [2:0] KC_RIGHT = 3'd3;
  localparam logic [2:0] KC_LEFT  = 3'd4;

  // Input word kinds carried in the slave-side tuser bit.
  localparam logic KIND_FEED = 1'b0;
  localparam logic KIND_POLL = 1'b1;

  // Bytes with a meaning to the parser.
  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_M       = 8'h4D;
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_B       = 8'h42;
  localparam logic [7:0] CH_C       = 8'h43;
  localparam logic [7:0] CH_D       = 8'h44;
  localparam logic [7:0] BTN_MASK   = 8'h03;
  localparam logic [7:0] BTN_RELBIT = 8'h20;
  localparam logic [8:0] COORD_BIAS = 9'd32;

  // One decoded event.
  typedef struct packed {
    ev_type_t          etype;
    logic [7:0]        key_char;
    logic [2:0]        key_code;
    logic [1:0]        mouse_button;
    logic              mouse_pressed;
    logic signed [8:0] mouse_x;
    logic signed [8:0] mouse_y;
  } event_t;

  localparam event_t EVENT_ZERO = '{
    etype:         EV_KEY,
    key_char:      8'd0,
    key_code:      KC_NONE,
    mouse_button:  2'd0,
    mouse_pressed: 1'b0,
    mouse_x:       9'sd0,
    mouse_y:       9'sd0
  };

endpackage

### rtl/tkmp_parser.sv
module tkmp_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            feed_en,
  input  logic [7:0]      feed_byte,
  input  logic            poll_en,
  output logic            held,
  output tkmp_pkg::event_t held_event
);
  import tkmp_pkg::*;

  parse_state_t state_r, state_nxt;
  logic [7:0]   button_r, button_nxt;
  logic [7:0]   column_r, column_nxt;
  logic         held_r, held_nxt;
  event_t       event_r, event_nxt;

  // Next state of the parser and of the held event.
  always_comb begin
    state_nxt  = state_r;
    button_nxt = button_r;
    column_nxt = column_r;
    held_nxt   = held_r;
    event_nxt  = event_r;
    if (poll_en) begin
      held_nxt = 1'b0;
    end else if (feed_en && !held_r) begin
      unique case (state_r)
        ST_ESC: begin
          if (feed_byte == CH_LBRACK) begin
            state_nxt = ST_CSI;
          end else begin
            event_nxt          = EVENT_ZERO;
            event_nxt.key_char = CH_ESC;
            held_nxt           = 1'b1;
            state_nxt          = ST_IDLE;
          end
        end
        ST_CSI: begin
          if (feed_byte == CH_M) begin
            state_nxt = ST_MBTN;
          end else begin
            event_nxt = EVENT_ZERO;
            held_nxt  = 1'b1;
            state_nxt = ST_IDLE;
            unique case (feed_byte)
              CH_A: begin
                event_nxt.etype    = EV_ARROW;
                event_nxt.key_code = KC_UP;
              end
              CH_B: begin
                event_nxt.etype    = EV_ARROW;
                event_nxt.key_code = KC_DOWN;
              end
              CH_C: begin
                event_nxt.etype    = EV_ARROW;
                event_nxt.key_code = KC_RIGHT;
              end
              CH_D: begin
                event_nxt.etype    = EV_ARROW;
                event_nxt.key_code = KC_LEFT;
              end
              default: begin
                event_nxt.etype = EV_KEY;
              end
            endcase
          end
        end
        ST_MBTN: begin
          button_nxt = feed_byte;
          state_nxt  = ST_MCOL;
        end
        ST_MCOL: begin
          column_nxt = feed_byte;
          state_nxt  = ST_MROW;
        end
        ST_MROW: begin
          event_nxt               = EVENT_ZERO;
          event_nxt.etype         = EV_MOUSE;
          event_nxt.mouse_button  = button_r[1:0] & BTN_MASK[1:0];
          event_nxt.mouse_pressed = ((button_r & BTN_RELBIT) == 8'd0);
          event_nxt.mouse_x       = $signed({1'b0, column_r} - COORD_BIAS);
          event_nxt.mouse_y       = $signed({1'b0, feed_byte} - COORD_BIAS);
          held_nxt                = 1'b1;
          state_nxt               = ST_IDLE;
        end
        default: begin
          // Idle, and any code that is not a parser state.
          if (feed_byte == CH_ESC) begin
            state_nxt = ST_ESC;
          end else begin
            event_nxt          = EVENT_ZERO;
            event_nxt.key_char = feed_byte;
            held_nxt           = 1'b1;
            state_nxt          = ST_IDLE;
          end
        end
      endcase
    end
  end

  // Parser state and held event registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      button_r <= 8'd0;
      column_r <= 8'd0;
      held_r   <= 1'b0;
      event_r  <= EVENT_ZERO;
    end else begin
      state_r  <= state_nxt;
      button_r <= button_nxt;
      column_r <= column_nxt;
      held_r   <= held_nxt;
      event_r  <= event_nxt;
    end
  end

  assign held       = held_r;
  assign held_event = event_r;

  // A poll always empties the holding slot.
  a_poll_clears: assert property (@(posedge clk) disable iff (!rst_n)
    poll_en |=> !held_r)
    else $error("held event survived a poll");

  // A byte fed while an event is held leaves the parser untouched.
  a_drop_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    (feed_en && !poll_en && held_r) |=> (held_r && $stable(state_r) && $stable(event_r)))
    else $error("byte fed while holding an event changed the parser");

  // A mouse event never carries key fields.
  a_mouse_no_key: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r && event_r.etype == EV_MOUSE) |-> (event_r.key_char == 8'd0 &&
      event_r.key_code == KC_NONE))
    else $error("mouse event with key fields set");

  // A new event is always stored with the parser back in idle.
  a_event_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(held_r) |-> (state_r == ST_IDLE))
    else $error("parser not idle after producing an event");

endmodule

### rtl/terminal_escape_key_mouse_parser_unit.sv
// Channel   Direction  Handshake              Payload
// in_       slave      in_tvalid/in_tready    tuser: kind; tdata: rx_byte
// out_      master     out_tvalid/out_tready  tuser: has_event, event_type;
//                                             tdata: key and mouse fields
//
// One word is taken per cycle; a feed updates the parser at the edge that
// accepts it and yields no result, a poll loads the result register at the
// edge that accepts it, so its result is offered from the next cycle on.
// The result register is the only buffer: input is accepted whenever it is
// empty or being drained in the same cycle, so a stalled result channel
// stalls the input. rst_n is synchronous and active low; it returns the
// parser to idle with no event held and empties the result register.
module terminal_escape_key_mouse_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [0:0]  in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] key_char, [10:8] key_code,
                                  // [12:11] mouse_button, [13] mouse_pressed,
                                  // [22:14] mouse_x, [31:23] mouse_y
  output logic [2:0]  out_tuser   // [0] has_event, [2:1] event_type
);
  import tkmp_pkg::*;

  logic   in_accept;
  logic   feed_en;
  logic   poll_en;
  logic   held;
  event_t held_event;
  logic   out_valid_r, out_valid_nxt;
  logic   out_has_r;
  event_t out_event_r;

  // Accept while the result register is free or emptying now.
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign feed_en   = in_accept && (in_tuser[0] == KIND_FEED);
  assign poll_en   = in_accept && (in_tuser[0] == KIND_POLL);

  tkmp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .feed_en    (feed_en),
    .feed_byte  (in_tdata),
    .poll_en    (poll_en),
    .held       (held),
    .held_event (held_event)
  );

  // Result valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (poll_en) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: the held event, or all zeros when nothing is held.
  always_ff @(posedge clk) begin
    if (poll_en) begin
      out_has_r   <= held;
      out_event_r <= held ? held_event : EVENT_ZERO;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_event_r.etype, out_has_r};
  assign out_tdata  = {out_event_r.mouse_y, out_event_r.mouse_x,
                       out_event_r.mouse_pressed, out_event_r.mouse_button,
                       out_event_r.key_code, out_event_r.key_char};

endmodule
